// ===== rtl/scw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scw_pkg: shared types and constants of the stack capture window
// Register indexes, reset values, window mode codes and the configuration
// bundle handed from the register file to the datapath.
// ----------------------------------------------------------------------------
package scw_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ABOVE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BELOW     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PTR_WIDTH = 3'd4;

  // window modes; any code above fixed selects stack plus frame
  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_FIXED = 2'd1;

  localparam logic [4:0] PTR_WIDTH_RST = 5'd8;

  // register stages from input to output register
  localparam int unsigned NUM_STAGES = 10;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] above;
    logic [31:0] below;
    logic [31:0] limit;
    logic [4:0]  ptr_width;
  } scw_cfg_t;

endpackage

// ===== rtl/scw_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scw_cfg_regs: configuration register file
// Write-only registers selected by index; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module scw_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [scw_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [scw_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  output scw_pkg::scw_cfg_t                   cfg_o
);
  import scw_pkg::*;

  scw_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode      <= MODE_NONE;
      cfg_q.above     <= '0;
      cfg_q.below     <= '0;
      cfg_q.limit     <= '0;
      cfg_q.ptr_width <= PTR_WIDTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:      cfg_q.mode      <= cfg_wdata_i[1:0];
        REG_ABOVE:     cfg_q.above     <= cfg_wdata_i;
        REG_BELOW:     cfg_q.below     <= cfg_wdata_i;
        REG_LIMIT:     cfg_q.limit     <= cfg_wdata_i;
        REG_PTR_WIDTH: cfg_q.ptr_width <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/scw_pipe_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scw_pipe_ctrl: valid bits and load enables of the datapath stages
// A stage loads when it is empty or when the stage after it moves on,
// so bubbles close up and a stall loses nothing.
// ----------------------------------------------------------------------------
module scw_pipe_ctrl #(
  parameter int unsigned Stages = scw_pkg::NUM_STAGES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_stall_i,
  output logic [Stages-1:0] ld_o,
  output logic [Stages-1:0] valid_o
);
  import scw_pkg::*;

  logic [Stages-1:0] v_q;
  logic [Stages-1:0] v_d;
  logic [Stages-1:0] ld;
  logic [Stages-1:0] prev;

  always_comb begin
    ld[Stages-1] = !v_q[Stages-1] || !out_stall_i;
    for (int k = int'(Stages) - 2; k >= 0; k--) begin
      ld[k] = !v_q[k] || ld[k+1];
    end
  end

  assign prev = {v_q[Stages-2:0], in_valid_i};
  assign v_d  = (ld & prev) | (~ld & v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign ld_o    = ld;
  assign valid_o = v_q;

endmodule

// ===== rtl/stack_capture_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_capture_window: capture segments around stack and frame pointers
// Turns one register snapshot into up to two merged memory segments to
// capture: a trimmed window around the stack pointer and, in frame mode,
// a two-pointer window at the frame pointer.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake                 word
//   -------  ---------  ------------------------  ---------------------------
//   in       input      in_valid_i / in_stall_o   sp, fp and readable flags
//   out      output     out_valid_o / out_stall_i segment count, two segments,
//                                                 frame missing flag
//   cfg      input      cfg_we_i                  index + 32-bit data
//
// Ten register stages, the last one being the output register. A word
// enters every cycle while the input is not stalled. Each stage holds
// one wide add or compare plus selection. Reset clears the valid bits and
// the configuration registers; stage payloads are not reset. A stall at the
// output holds only the stages that are full behind it, so empty stages
// keep filling and the input accepts words until the pipeline is full.
// ----------------------------------------------------------------------------
module stack_capture_window (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [scw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [scw_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // snapshot in
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [63:0]                    sp_value_i,
  input  logic                           sp_readable_i,
  input  logic [63:0]                    fp_value_i,
  input  logic                           fp_readable_i,
  // segments out
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     segment_count_o,
  output logic [63:0]                    first_base_o,
  output logic [63:0]                    first_size_o,
  output logic [63:0]                    second_base_o,
  output logic [63:0]                    second_size_o,
  output logic                           frame_window_missing_o
);
  import scw_pkg::*;

  scw_cfg_t              cfg;
  logic [NUM_STAGES-1:0] ld;
  logic [NUM_STAGES-1:0] vld;

  // ---------------- stage 1: stack window and raw segment ends ------------
  logic [31:0] bl_c;
  logic [63:0] base_c;
  logic [32:0] wsz_c;
  logic [64:0] aesum_c;
  logic [5:0]  fpsz_c;
  logic [64:0] besum_c;
  logic        frame_c, kill_c, fpv_c;

  logic        kill1_q, frame1_q, fpv1_q;
  logic [63:0] base1_q, ae1_q, fp1_q, be1_q;
  logic [31:0] bl1_q;
  logic [32:0] wsz1_q;
  logic [5:0]  fpsz1_q;

  // ---------------- stage 2: overlap bounds, budget after frame -----------
  logic [63:0] s_c, e_c;
  logic [31:0] avail_c;

  logic        kill2_q, frame2_q, fpv2_q;
  logic [63:0] base2_q, fp2_q, be2_q, s2_q, e2_q;
  logic [31:0] bl2_q, avail2_q;
  logic [32:0] wsz2_q;
  logic [5:0]  fpsz2_q;

  // ---------------- stage 3: overlap length -------------------------------
  logic [63:0] ovdiff_c;
  logic [5:0]  ov_c;

  logic        kill3_q, frame3_q, fpv3_q;
  logic [63:0] base3_q, fp3_q, be3_q;
  logic [31:0] bl3_q, avail3_q;
  logic [32:0] wsz3_q;
  logic [5:0]  fpsz3_q, ov3_q;

  // ---------------- stage 4: effective limit ------------------------------
  logic [32:0] limsum_c, limit_c;
  logic        uselim_c;

  logic        kill4_q, frame4_q, fpv4_q;
  logic [63:0] base4_q, fp4_q, be4_q;
  logic [31:0] bl4_q;
  logic [32:0] wsz4_q, limit4_q;
  logic [5:0]  fpsz4_q;

  // ---------------- stage 5: trim decision --------------------------------
  logic        dotrim_c;
  logic [32:0] tsize_c;
  logic [31:0] delta_c;

  logic        kill5_q, frame5_q, fpv5_q;
  logic [63:0] base5_q, fp5_q, be5_q;
  logic [32:0] tsize5_q;
  logic [31:0] delta5_q;
  logic [5:0]  fpsz5_q;

  // ---------------- stage 6: trimmed base ---------------------------------
  logic        kill6_q, frame6_q, fpv6_q;
  logic [63:0] tbase6_q, fp6_q, be6_q;
  logic [32:0] tsize6_q;
  logic [5:0]  fpsz6_q;

  // ---------------- stage 7: trimmed end ----------------------------------
  logic [64:0] endsum_c;

  logic        kill7_q, frame7_q, fpv7_q;
  logic [63:0] tbase7_q, enda7_q, fp7_q, be7_q;
  logic [32:0] tsize7_q;
  logic [5:0]  fpsz7_q;

  // ---------------- stage 8: sort by base ---------------------------------
  logic        aval_c, swap_c;
  logic [32:0] fps_c;

  logic        kill8_q, frame8_q, fpv8_q;
  logic [1:0]  cnt8_q;
  logic [63:0] b08_q, e08_q, b18_q, e18_q;
  logic [32:0] s08_q, s18_q;

  // ---------------- stage 9: merge test -----------------------------------
  logic        kill9_q, miss9_q, sep9_q;
  logic [1:0]  cnt9_q;
  logic [63:0] b09_q, b19_q, emax9_q;
  logic [32:0] s09_q, s19_q;

  // ---------------- stage 10: output register -----------------------------
  logic [1:0]  cnt_d, cnt_q;
  logic [63:0] fb_d, fs_d, sb_d, ss_d;
  logic [63:0] fb_q, fs_q, sb_q, ss_q;
  logic        miss_d, miss_q;

  scw_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  scw_pipe_ctrl #(
    .Stages (NUM_STAGES)
  ) u_pipe_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .ld_o        (ld),
    .valid_o     (vld)
  );

  assign in_stall_o  = !ld[0];
  assign out_valid_o = vld[NUM_STAGES-1];

  // Stage 1: clamp the below part at address zero. The window end is
  // sp + above in every case, so saturate that sum directly.
  assign frame_c = (cfg.mode != MODE_NONE) && (cfg.mode != MODE_FIXED);
  assign kill_c  = (cfg.mode == MODE_NONE) || !sp_readable_i || (sp_value_i == '0);
  assign fpv_c   = frame_c && fp_readable_i && (fp_value_i != '0) &&
                   (cfg.ptr_width != '0);
  assign bl_c    = (sp_value_i < {32'b0, cfg.below}) ? sp_value_i[31:0]
                                                     : cfg.below;
  assign base_c  = sp_value_i - {32'b0, bl_c};
  assign wsz_c   = {1'b0, bl_c} + {1'b0, cfg.above};
  assign aesum_c = {1'b0, sp_value_i} + {33'b0, cfg.above};
  assign fpsz_c  = {cfg.ptr_width, 1'b0};
  assign besum_c = {1'b0, fp_value_i} + {59'b0, fpsz_c};

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      kill1_q  <= kill_c;
      frame1_q <= frame_c;
      fpv1_q   <= fpv_c;
      base1_q  <= base_c;
      bl1_q    <= bl_c;
      wsz1_q   <= wsz_c;
      ae1_q    <= aesum_c[64] ? '1 : aesum_c[63:0];
      fp1_q    <= fp_value_i;
      fpsz1_q  <= fpsz_c;
      be1_q    <= besum_c[64] ? '1 : besum_c[63:0];
    end
  end

  // Stage 2: overlap runs from the larger base to the smaller end; the
  // frame window comes out of the byte budget first.
  assign s_c     = (base1_q > fp1_q) ? base1_q : fp1_q;
  assign e_c     = (ae1_q < be1_q) ? ae1_q : be1_q;
  assign avail_c = (cfg.limit > {26'b0, fpsz1_q}) ?
                   cfg.limit - {26'b0, fpsz1_q} : '0;

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      kill2_q  <= kill1_q;
      frame2_q <= frame1_q;
      fpv2_q   <= fpv1_q;
      base2_q  <= base1_q;
      bl2_q    <= bl1_q;
      wsz2_q   <= wsz1_q;
      fp2_q    <= fp1_q;
      fpsz2_q  <= fpsz1_q;
      be2_q    <= be1_q;
      s2_q     <= s_c;
      e2_q     <= e_c;
      avail2_q <= avail_c;
    end
  end

  // Stage 3: overlap never exceeds the frame window, so six bits hold it
  // whenever the frame window is valid.
  assign ovdiff_c = e2_q - s2_q;
  assign ov_c     = (s2_q >= e2_q) ? 6'd0 : ovdiff_c[5:0];

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      kill3_q  <= kill2_q;
      frame3_q <= frame2_q;
      fpv3_q   <= fpv2_q;
      base3_q  <= base2_q;
      bl3_q    <= bl2_q;
      wsz3_q   <= wsz2_q;
      fp3_q    <= fp2_q;
      fpsz3_q  <= fpsz2_q;
      be3_q    <= be2_q;
      avail3_q <= avail2_q;
      ov3_q    <= ov_c;
    end
  end

  // Stage 4: no limit when the total is zero; else the frame-adjusted limit
  // only if the frame window is valid and the stack window exceeds it.
  assign limsum_c = {1'b0, avail3_q} + {27'b0, ov3_q};
  assign uselim_c = fpv3_q && (wsz3_q > limsum_c);
  assign limit_c  = (cfg.limit == '0) ? '0 :
                    uselim_c ? limsum_c : {1'b0, cfg.limit};

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      kill4_q  <= kill3_q;
      frame4_q <= frame3_q;
      fpv4_q   <= fpv3_q;
      base4_q  <= base3_q;
      bl4_q    <= bl3_q;
      wsz4_q   <= wsz3_q;
      fp4_q    <= fp3_q;
      fpsz4_q  <= fpsz3_q;
      be4_q    <= be3_q;
      limit4_q <= limit_c;
    end
  end

  // Stage 5: trimming drops the above part first, so a trimmed window is
  // exactly limit bytes and keeps min(below, limit) under the pointer.
  // The base moves up by what was cut from below.
  assign dotrim_c = (wsz4_q != '0) && (limit4_q != '0) && (wsz4_q > limit4_q);
  assign tsize_c  = dotrim_c ? limit4_q : wsz4_q;
  assign delta_c  = (dotrim_c && ({1'b0, bl4_q} > limit4_q)) ?
                    bl4_q - limit4_q[31:0] : '0;

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      kill5_q  <= kill4_q;
      frame5_q <= frame4_q;
      fpv5_q   <= fpv4_q;
      base5_q  <= base4_q;
      tsize5_q <= tsize_c;
      delta5_q <= delta_c;
      fp5_q    <= fp4_q;
      fpsz5_q  <= fpsz4_q;
      be5_q    <= be4_q;
    end
  end

  // Stage 6: advance the base
  always_ff @(posedge clk_i) begin
    if (ld[5]) begin
      kill6_q  <= kill5_q;
      frame6_q <= frame5_q;
      fpv6_q   <= fpv5_q;
      tbase6_q <= base5_q + {32'b0, delta5_q};
      tsize6_q <= tsize5_q;
      fp6_q    <= fp5_q;
      fpsz6_q  <= fpsz5_q;
      be6_q    <= be5_q;
    end
  end

  // Stage 7: saturated end of the trimmed stack window
  assign endsum_c = {1'b0, tbase6_q} + {32'b0, tsize6_q};

  always_ff @(posedge clk_i) begin
    if (ld[6]) begin
      kill7_q  <= kill6_q;
      frame7_q <= frame6_q;
      fpv7_q   <= fpv6_q;
      tbase7_q <= tbase6_q;
      tsize7_q <= tsize6_q;
      enda7_q  <= endsum_c[64] ? '1 : endsum_c[63:0];
      fp7_q    <= fp6_q;
      fpsz7_q  <= fpsz6_q;
      be7_q    <= be6_q;
    end
  end

  // Stage 8: put the lower segment in slot 0. With a single segment it
  // lands in slot 0 as well.
  assign aval_c = (tsize7_q != '0);
  assign swap_c = fpv7_q && (!aval_c || (fp7_q < tbase7_q));
  assign fps_c  = {27'b0, fpsz7_q};

  always_ff @(posedge clk_i) begin
    if (ld[7]) begin
      kill8_q  <= kill7_q;
      frame8_q <= frame7_q;
      fpv8_q   <= fpv7_q;
      cnt8_q   <= {1'b0, aval_c} + {1'b0, fpv7_q};
      b08_q    <= swap_c ? fp7_q    : tbase7_q;
      s08_q    <= swap_c ? fps_c    : tsize7_q;
      e08_q    <= swap_c ? be7_q    : enda7_q;
      b18_q    <= swap_c ? tbase7_q : fp7_q;
      s18_q    <= swap_c ? tsize7_q : fps_c;
      e18_q    <= swap_c ? enda7_q  : be7_q;
    end
  end

  // Stage 9: separate only when the upper base lies past the lower end
  always_ff @(posedge clk_i) begin
    if (ld[8]) begin
      kill9_q <= kill8_q;
      miss9_q <= frame8_q && !fpv8_q;
      cnt9_q  <= cnt8_q;
      b09_q   <= b08_q;
      s09_q   <= s08_q;
      b19_q   <= b18_q;
      s19_q   <= s18_q;
      sep9_q  <= b18_q > e08_q;
      emax9_q <= (e08_q > e18_q) ? e08_q : e18_q;
    end
  end

  // Stage 10: format the word; unused segment fields read as zero
  always_comb begin
    cnt_d  = 2'd0;
    fb_d   = '0;
    fs_d   = '0;
    sb_d   = '0;
    ss_d   = '0;
    miss_d = 1'b0;
    if (!kill9_q) begin
      miss_d = miss9_q;
      if (cnt9_q == 2'd2) begin
        if (sep9_q) begin
          cnt_d = 2'd2;
          fb_d  = b09_q;
          fs_d  = {31'b0, s09_q};
          sb_d  = b19_q;
          ss_d  = {31'b0, s19_q};
        end else begin
          cnt_d = 2'd1;
          fb_d  = b09_q;
          fs_d  = emax9_q - b09_q;
        end
      end else if (cnt9_q == 2'd1) begin
        cnt_d = 2'd1;
        fb_d  = b09_q;
        fs_d  = {31'b0, s09_q};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[9]) begin
      cnt_q  <= cnt_d;
      fb_q   <= fb_d;
      fs_q   <= fs_d;
      sb_q   <= sb_d;
      ss_q   <= ss_d;
      miss_q <= miss_d;
    end
  end

  assign segment_count_o        = cnt_q;
  assign first_base_o           = fb_q;
  assign first_size_o           = fs_q;
  assign second_base_o          = sb_q;
  assign second_size_o          = ss_q;
  assign frame_window_missing_o = miss_q;

endmodule

// ===== sim/stack_capture_window_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_capture_window_checker: segment predictor and result scoreboard
// Watches the configuration port and both word channels of the stack capture
// window, predicts the segments of every accepted snapshot and compares each
// accepted result word with the oldest prediction still due.
// ----------------------------------------------------------------------------
module stack_capture_window_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [scw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [scw_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [63:0]                    sp_value_i,
  input  logic                           sp_readable_i,
  input  logic [63:0]                    fp_value_i,
  input  logic                           fp_readable_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [1:0]                     segment_count_i,
  input  logic [63:0]                    first_base_i,
  input  logic [63:0]                    first_size_i,
  input  logic [63:0]                    second_base_i,
  input  logic [63:0]                    second_size_i,
  input  logic                           frame_window_missing_i,
  output int unsigned                    mismatches_o,
  output int unsigned                    pending_o,
  output int unsigned                    checked_o
);
  import scw_pkg::*;

  typedef struct packed {
    logic [1:0]  count;
    logic [63:0] first_base;
    logic [63:0] first_size;
    logic [63:0] second_base;
    logic [63:0] second_size;
    logic        missing;
  } seg_result_t;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] size;
    logic [63:0] below;
    logic [63:0] above;
  } span_t;

  logic [1:0]  cfg_mode;
  logic [31:0] cfg_above;
  logic [31:0] cfg_below;
  logic [31:0] cfg_total;
  logic [4:0]  cfg_ptr;

  seg_result_t segments_due[$];

  // saturate the end address at the top of the address space
  function automatic logic [63:0] span_end(logic [63:0] base, logic [63:0] size);
    logic [64:0] sum;
    sum = {1'b0, base} + {1'b0, size};
    if (size == 64'd0) return base;
    return sum[64] ? {64{1'b1}} : sum[63:0];
  endfunction

  // cut the excess from above the stack pointer first, then from below
  function automatic span_t trim_span(span_t w, logic [63:0] limit);
    logic [63:0] excess;
    logic [63:0] cut;
    span_t       t;
    if (w.size == 64'd0 || limit == 64'd0 || w.size <= limit) return w;
    excess = w.size - limit;
    t = w;
    cut = (t.above < excess) ? t.above : excess;
    t.above -= cut;
    excess -= cut;
    cut = (t.below < excess) ? t.below : excess;
    t.below -= cut;
    t.base = w.base + (w.below - t.below);
    t.size = t.below + t.above;
    return t;
  endfunction

  function automatic seg_result_t predict_segments(logic [63:0] sp, logic sp_ok,
                                                   logic [63:0] fp, logic fp_ok);
    seg_result_t r;
    span_t       w;
    logic [63:0] clamp, fp_size, limit, stack_end, frame_end;
    logic [63:0] ov_lo, ov_hi, overlap, avail;
    logic [63:0] lo_base, lo_size, hi_base, hi_size, lo_end, hi_end;
    logic        frame_ok;
    r = '0;
    if (cfg_mode == MODE_NONE || !sp_ok || sp == 64'd0) return r;

    clamp   = (sp < {32'd0, cfg_below}) ? sp : {32'd0, cfg_below};
    w.base  = sp - clamp;
    w.below = clamp;
    w.above = {32'd0, cfg_above};
    w.size  = clamp + w.above;

    if (cfg_mode == MODE_FIXED) begin
      w = trim_span(w, {32'd0, cfg_total});
      if (w.size != 64'd0) begin
        r.count      = 2'd1;
        r.first_base = w.base;
        r.first_size = w.size;
      end
      return r;
    end

    // every code above fixed adds the frame window
    frame_ok  = fp_ok && fp != 64'd0 && cfg_ptr != 5'd0;
    fp_size   = frame_ok ? {58'd0, cfg_ptr, 1'b0} : 64'd0;
    r.missing = !frame_ok;

    if (cfg_total != 32'd0) begin
      limit = {32'd0, cfg_total};
      if (frame_ok) begin
        // the frame window takes its share of the limit, minus what it shares
        stack_end = span_end(w.base, w.size);
        frame_end = span_end(fp, fp_size);
        ov_lo     = (w.base > fp) ? w.base : fp;
        ov_hi     = (stack_end < frame_end) ? stack_end : frame_end;
        overlap   = (ov_lo >= ov_hi) ? 64'd0 : ov_hi - ov_lo;
        avail     = ({32'd0, cfg_total} > fp_size) ? {32'd0, cfg_total} - fp_size : 64'd0;
        if (w.size > avail + overlap) limit = avail + overlap;
      end
      w = trim_span(w, limit);
    end

    if (w.size != 64'd0 && frame_ok) begin
      if (fp < w.base) begin
        lo_base = fp;     lo_size = fp_size;
        hi_base = w.base; hi_size = w.size;
      end else begin
        lo_base = w.base; lo_size = w.size;
        hi_base = fp;     hi_size = fp_size;
      end
      lo_end = span_end(lo_base, lo_size);
      hi_end = span_end(hi_base, hi_size);
      r.first_base = lo_base;
      if (hi_base > lo_end) begin
        r.count       = 2'd2;
        r.first_size  = lo_size;
        r.second_base = hi_base;
        r.second_size = hi_size;
      end else begin
        r.count      = 2'd1;
        r.first_size = ((lo_end > hi_end) ? lo_end : hi_end) - lo_base;
      end
    end else if (w.size != 64'd0) begin
      r.count      = 2'd1;
      r.first_base = w.base;
      r.first_size = w.size;
    end else if (frame_ok) begin
      r.count      = 2'd1;
      r.first_base = fp;
      r.first_size = fp_size;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    seg_result_t got;
    seg_result_t want;
    if (!rst_ni) begin
      cfg_mode  <= MODE_NONE;
      cfg_above <= '0;
      cfg_below <= '0;
      cfg_total <= '0;
      cfg_ptr   <= PTR_WIDTH_RST;
      segments_due.delete();
      mismatches_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MODE:      cfg_mode  <= cfg_wdata_i[1:0];
          REG_ABOVE:     cfg_above <= cfg_wdata_i;
          REG_BELOW:     cfg_below <= cfg_wdata_i;
          REG_LIMIT:     cfg_total <= cfg_wdata_i;
          REG_PTR_WIDTH: cfg_ptr   <= cfg_wdata_i[4:0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        segments_due.insert(segments_due.size(),
                            predict_segments(sp_value_i, sp_readable_i,
                                             fp_value_i, fp_readable_i));
      end

      if (out_valid_i && !out_stall_i) begin
        got = '{segment_count_i, first_base_i, first_size_i,
                second_base_i, second_size_i, frame_window_missing_i};
        if (segments_due.size() == 0) begin
          if (mismatches_o < 10)
            $display("checker: result word %0d arrived with no snapshot pending", checked_o);
          mismatches_o <= mismatches_o + 1;
        end else begin
          want = segments_due.pop_front();
          if (want !== got) begin
            if (mismatches_o < 10) begin
              $display("checker: word %0d expected cnt %0d %h+%h %h+%h miss %0b", checked_o,
                       want.count, want.first_base, want.first_size,
                       want.second_base, want.second_size, want.missing);
              $display("checker: word %0d actual   cnt %0d %h+%h %h+%h miss %0b", checked_o,
                       got.count, got.first_base, got.first_size,
                       got.second_base, got.second_size, got.missing);
            end
            mismatches_o <= mismatches_o + 1;
          end
        end
        checked_o <= checked_o + 1;
      end

      pending_o <= segments_due.size();
    end
  end

endmodule

// ===== sim/stack_capture_window_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_capture_window_tb: self-checking bench for the stack capture window
// Loads a series of register settings, offers a directed set of snapshots
// and then random ones under changing idle and stall patterns, including a
// long output hold that backs the pipeline up. A checker beside the block
// predicts every result word and counts mismatches.
// ----------------------------------------------------------------------------
module stack_capture_window_tb;
  import scw_pkg::*;

  // codes above fixed select stack plus frame; the package names only two
  localparam logic [1:0] MODE_FRAME     = 2'd2;
  localparam logic [1:0] MODE_FRAME_ALT = 2'd3;

  localparam int unsigned RAND_PHASES     = 19;
  localparam int unsigned WORDS_PER_PHASE = 50;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned QUIET_LIMIT     = 4000;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_kind_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [63:0]           sp_value_i;
  logic                  sp_readable_i;
  logic [63:0]           fp_value_i;
  logic                  fp_readable_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [1:0]            segment_count_o;
  logic [63:0]           first_base_o;
  logic [63:0]           first_size_o;
  logic [63:0]           second_base_o;
  logic [63:0]           second_size_o;
  logic                  frame_window_missing_o;

  int unsigned mismatches;
  int unsigned words_due;
  int unsigned words_checked;

  idle_kind_t  idle_mode = IDLE_NONE;
  int unsigned pressure_reqs = 0;
  int unsigned snapshots_sent = 0;
  int unsigned settings_loaded = 0;
  int unsigned quiet_cycles = 0;

  stack_capture_window dut (.*);

  stack_capture_window_checker checker_i (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we_i),
    .cfg_idx_i              (cfg_idx_i),
    .cfg_wdata_i            (cfg_wdata_i),
    .in_valid_i             (in_valid_i),
    .in_stall_i             (in_stall_o),
    .sp_value_i             (sp_value_i),
    .sp_readable_i          (sp_readable_i),
    .fp_value_i             (fp_value_i),
    .fp_readable_i          (fp_readable_i),
    .out_valid_i            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .segment_count_i        (segment_count_o),
    .first_base_i           (first_base_o),
    .first_size_i           (first_size_o),
    .second_base_i          (second_base_o),
    .second_size_i          (second_size_o),
    .frame_window_missing_i (frame_window_missing_o),
    .mismatches_o           (mismatches),
    .pending_o              (words_due),
    .checked_o              (words_checked)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic bit chance(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // pick a byte count: mostly small, with both extremes and full-range values
  function automatic logic [31:0] pick_bytes();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom_range(0, 256);
      4:       return $urandom_range(0, 65536);
      default: return $urandom;
    endcase
  endfunction

  // Output side: random stalls per the idle pattern. A pressure request
  // from the main flow starts a long hold, counted here, so the pipeline
  // backs up and stalls its input while words keep being offered.
  initial begin
    int unsigned hold_left;
    int unsigned served;
    hold_left   = 0;
    served      = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (served != pressure_reqs) begin
        served    = pressure_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (idle_mode == IDLE_RECEIVER) begin
        out_stall_i <= chance(64);
      end else if (idle_mode == IDLE_BOTH) begin
        out_stall_i <= chance(34);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when no word and no register write moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one snapshot word; hold it until the block takes it.
  task automatic offer(input logic [63:0] sp, input logic sp_ok,
                       input logic [63:0] fp, input logic fp_ok);
    while ((idle_mode == IDLE_SENDER && chance(64)) ||
           (idle_mode == IDLE_BOTH && chance(34))) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sp_value_i    <= sp;
    sp_readable_i <= sp_ok;
    fp_value_i    <= fp;
    fp_readable_i <= fp_ok;
    do @(posedge clk_i); while (in_stall_o);
    snapshots_sent++;
  endtask

  // Drop valid and wait until every predicted result word has come back.
  // It waits for a clock edge first, so the word taken last is already counted.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (words_due != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // Registers change only with the pipeline empty.
  task automatic load_settings(input logic [1:0] mode, input logic [31:0] above,
                               input logic [31:0] below, input logic [31:0] total,
                               input logic [4:0] ptr);
    settle();
    write_reg(REG_MODE, {30'd0, mode});
    write_reg(REG_ABOVE, above);
    write_reg(REG_BELOW, below);
    write_reg(REG_LIMIT, total);
    write_reg(REG_PTR_WIDTH, {27'd0, ptr});
    cfg_we_i <= 1'b0;
    settings_loaded++;
  endtask

  task automatic run_directed();
    // frame mode, no limit: unreadable and zero pointers, clamping at zero,
    // merging by overlap and by touching, sorting, and the top of memory
    load_settings(MODE_FRAME, 32'd64, 32'd128, 32'd0, 5'd8);
    offer(64'h1000, 1'b0, 64'h2000, 1'b1);
    offer(64'h0, 1'b1, 64'h2000, 1'b1);
    offer(64'h1000, 1'b1, 64'h2000, 1'b0);
    offer(64'h1000, 1'b1, 64'h0, 1'b1);
    offer(64'h40, 1'b1, 64'h2000, 1'b1);
    offer(64'h1000, 1'b1, 64'h1010, 1'b1);
    offer(64'h1000, 1'b1, 64'h1040, 1'b1);
    offer(64'h1000, 1'b1, 64'hF70, 1'b1);
    offer(64'h1000, 1'b1, 64'h100, 1'b1);
    offer(~64'h10, 1'b1, ~64'h4, 1'b1);
    offer(~64'h0, 1'b1, ~64'h0, 1'b1);

    // fixed window: empty window, then full-range counts trimmed hard
    load_settings(MODE_FIXED, 32'd0, 32'd0, 32'd0, 5'd8);
    offer(64'h5000, 1'b1, 64'h5000, 1'b1);
    load_settings(MODE_FIXED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd100, 5'd8);
    offer(64'h5000, 1'b1, 64'h5000, 1'b1);
    offer(~64'h0, 1'b1, 64'h0, 1'b0);

    // frame limit with and without overlap
    load_settings(MODE_FRAME, 32'd1000, 32'd1000, 32'd100, 5'd16);
    offer(64'h10000, 1'b1, 64'h10010, 1'b1);
    offer(64'h10000, 1'b1, 64'h20000, 1'b1);
    // limit below the frame window, and a limit that comes out as zero
    load_settings(MODE_FRAME_ALT, 32'd0, 32'd0, 32'd20, 5'd16);
    offer(64'h3000, 1'b1, 64'h3000, 1'b1);
    load_settings(MODE_FRAME, 32'd50, 32'd50, 32'd32, 5'd16);
    offer(64'h9000, 1'b1, 64'h100, 1'b1);

    // zero pointer width, mode none, widest pointer field
    load_settings(MODE_FRAME, 32'd8, 32'd8, 32'd0, 5'd0);
    offer(64'h800, 1'b1, 64'h800, 1'b1);
    load_settings(MODE_NONE, 32'd8, 32'd8, 32'd0, 5'd31);
    offer(64'h800, 1'b1, 64'h810, 1'b1);
    load_settings(MODE_FRAME, 32'd8, 32'd8, 32'd0, 5'd31);
    offer(64'h800, 1'b1, 64'h810, 1'b1);
  endtask

  task automatic run_random_phase(input int unsigned ph);
    logic [1:0]  mode;
    logic [31:0] above, below, total;
    logic [4:0]  ptr;
    logic [63:0] sp, fp;
    int unsigned pick;
    case (ph)
      0: begin
        mode = MODE_FRAME; above = '1; below = '1; total = '1; ptr = 5'd16;
      end
      1: begin
        mode = MODE_FRAME_ALT; above = '0; below = '0; total = '0; ptr = 5'd31;
      end
      2: begin
        mode = MODE_FIXED; above = '1; below = '1; total = 32'd1; ptr = 5'd1;
      end
      default: begin
        pick  = $urandom_range(0, 9);
        mode  = (pick == 0) ? MODE_NONE : (pick < 4) ? MODE_FIXED :
                (pick < 9) ? MODE_FRAME : MODE_FRAME_ALT;
        above = pick_bytes();
        below = pick_bytes();
        total = pick_bytes();
        ptr   = chance(10) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 16));
      end
    endcase
    load_settings(mode, above, below, total, ptr);

    // every seventh phase from the fourth on: long output hold, full-rate input
    if (ph % 7 == 3) begin
      idle_mode     <= IDLE_NONE;
      pressure_reqs <= pressure_reqs + 1;
    end else begin
      idle_mode <= idle_kind_t'(ph % 4);
    end

    for (int unsigned n = 0; n < WORDS_PER_PHASE; n++) begin
      case ($urandom_range(0, 3))
        0:       sp = 64'($urandom_range(0, 4096));
        1:       sp = ~64'($urandom_range(0, 4096));
        default: sp = {$urandom, $urandom};
      endcase
      if (chance(3)) sp = 64'd0;
      // mostly aim the frame pointer at the stack window edges or at sp
      case ($urandom_range(0, 4))
        0:       fp = sp + above + 64'($urandom_range(0, 64)) - 64'd32;
        1:       fp = sp - below + 64'($urandom_range(0, 64)) - 64'd48;
        2:       fp = sp + 64'($urandom_range(0, 128)) - 64'd64;
        3:       fp = {$urandom, $urandom};
        default: fp = ~64'($urandom_range(0, 64));
      endcase
      if (chance(3)) fp = 64'd0;
      offer(sp, chance(92), fp, chance(90));
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_MODE;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    sp_value_i    = '0;
    sp_readable_i = 1'b0;
    fp_value_i    = '0;
    fp_readable_i = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    for (int unsigned p = 0; p < RAND_PHASES; p++) run_random_phase(p);
    settle();
    repeat (2 * NUM_STAGES) @(posedge clk_i);

    $display("tb: %0d snapshots under %0d register settings, %0d result words checked",
             snapshots_sent, settings_loaded, words_checked);
    $display("tb: idle patterns none/sender/receiver/both, %0d long output holds",
             pressure_reqs);
    if (mismatches == 0 && words_due == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/scw_pkg.sv
rtl/scw_cfg_regs.sv
rtl/scw_pipe_ctrl.sv
rtl/stack_capture_window.sv
sim/stack_capture_window_checker.sv
sim/stack_capture_window_tb.sv
